[sv/sct_pkg.sv]
// Shared constants, types and elaboration-time helpers for the sine/cosine series unit.
// No dependencies; every other file of the unit imports this package.
package sct_pkg;

    localparam int ANGLE_W = 22;
    localparam int VALUE_W = 24;

    localparam int SERIES_TERMS_DEF  = 4;
    localparam int FRACTION_BITS_DEF = 16;

    // 2*pi with 32 fraction bits.
    localparam longint unsigned TWO_PI_Q32 = 64'h6_487E_D511;

    // Operation selector codes.
    localparam logic OP_SINE   = 1'b0;
    localparam logic OP_COSINE = 1'b1;

    // Control that travels with every pipeline stage.
    typedef struct packed {
        logic valid;
        logic cosine;
        logic neg;
    } ctl_t;

    // 2*pi rounded half up to the given number of fraction bits.
    function automatic longint unsigned two_pi_fx(input int frac);
        return (TWO_PI_Q32 + (64'd1 << (31 - frac))) >> (32 - frac);
    endfunction

    // Number of quotient bits needed to reduce any angle magnitude by the divisor.
    function automatic int red_bits(input longint unsigned div);
        int qb;
        qb = 1;
        for (int b = 1; b < 48; b++) begin
            if ((div << b) <= (64'd1 << (ANGLE_W - 1))) begin
                qb = b + 1;
            end
        end
        return qb;
    endfunction

endpackage

[sv/sine_cosine_taylor_unit.sv]
// Top level of the truncated Taylor-series sine/cosine unit.
// Depends on sct_pkg, sct_reduce, sct_step and sct_output.
//
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid, in_stall   operation (1), angle (22, signed Q5.16)
//   output    out        out_valid, out_stall value (24, signed Q7.16, saturated)
//
// One transaction enters per cycle unless a stall holds the pipeline, and every
// transaction yields exactly one result. QB is the number of 2*pi reduction stages
// (3 at 16 fraction bits), set by sct_pkg::red_bits.
// Each series step costs two stages: a multiply by |x| and a reciprocal multiply by 1/n.
// Reset clears only the control words that travel with the data, not the data.
// A stall on a valid output freezes the whole pipeline and stalls the input in the same
// cycle, so no transaction is dropped or repeated.
module sine_cosine_taylor_unit #(
    parameter int SERIES_TERMS  = sct_pkg::SERIES_TERMS_DEF,
    parameter int FRACTION_BITS = sct_pkg::FRACTION_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               operation,
    input  logic signed [sct_pkg::ANGLE_W-1:0] angle,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [sct_pkg::VALUE_W-1:0] value
);
    import sct_pkg::*;

    localparam int TW    = FRACTION_BITS + 8;
    localparam int AXW   = FRACTION_BITS + 3;
    localparam int SW    = FRACTION_BITS + 12;
    localparam int STEPS = 2 * SERIES_TERMS;

    logic en;

    // Pipeline links between series steps; link 0 is the reduced angle.
    ctl_t                 ctl_w [0:STEPS];
    logic [TW-1:0]        t_w   [0:STEPS];
    logic [AXW-1:0]       ax_w  [0:STEPS];
    logic signed [SW-1:0] sum_w [0:STEPS];

    // The pipeline advances whenever the output register is empty or being taken.
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    sct_reduce #(
        .FRAC(FRACTION_BITS)
    ) u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .operation(operation),
        .angle    (angle),
        .ctl_out  (ctl_w[0]),
        .ax_out   (ax_w[0])
    );

    // Sine starts its term at |x|, cosine at 1.0; the running sum starts at zero and
    // the first step adds the starting term.
    assign t_w[0]   = ctl_w[0].cosine ? (TW'(1) << FRACTION_BITS) : TW'(ax_w[0]);
    assign sum_w[0] = '0;

    for (genvar j = 0; j < STEPS; j++)
    begin : g_step
        sct_step #(
            .FRAC(FRACTION_BITS),
            .STEP(j)
        ) u_step (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .ctl_in (ctl_w[j]),
            .t_in   (t_w[j]),
            .ax_in  (ax_w[j]),
            .sum_in (sum_w[j]),
            .ctl_out(ctl_w[j+1]),
            .t_out  (t_w[j+1]),
            .ax_out (ax_w[j+1]),
            .sum_out(sum_w[j+1])
        );
    end

    sct_output #(
        .FRAC (FRACTION_BITS),
        .TERMS(SERIES_TERMS)
    ) u_output (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctl_in   (ctl_w[STEPS]),
        .t_in     (t_w[STEPS]),
        .sum_in   (sum_w[STEPS]),
        .out_valid(out_valid),
        .value    (value)
    );

endmodule

[sv/sct_reduce.sv]
// Front end of the series unit: takes the angle magnitude and reduces it modulo 2*pi.
// Depends on sct_pkg; one restoring compare-and-subtract per reduction stage.
module sct_reduce #(
    parameter int FRAC = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic                              operation,
    input  logic signed [sct_pkg::ANGLE_W-1:0] angle,
    output sct_pkg::ctl_t                     ctl_out,
    output logic [FRAC+2:0]                   ax_out
);
    import sct_pkg::*;

    localparam longint unsigned TWO_PI = two_pi_fx(FRAC);
    localparam int QB  = red_bits(TWO_PI);
    localparam int AXW = FRAC + 3;
    localparam int RW  = (ANGLE_W > AXW) ? ANGLE_W : AXW;

    ctl_t            ctl_reg [0:QB];
    logic [RW-1:0]   rem_reg [0:QB];
    logic [ANGLE_W-1:0] angle_u;
    logic [ANGLE_W-1:0] mag_next;

    assign angle_u  = $unsigned(angle);
    assign mag_next = angle_u[ANGLE_W-1] ? (~angle_u + 1'b1) : angle_u;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else if (en)
        begin
            ctl_reg[0].valid  <= in_valid;
            ctl_reg[0].cosine <= (operation == OP_COSINE);
            ctl_reg[0].neg    <= angle_u[ANGLE_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= RW'(mag_next);
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_stage
        localparam logic [RW-1:0] DIV = RW'(TWO_PI << (QB - k));
        logic [RW-1:0] rem_next;

        assign rem_next = (rem_reg[k-1] >= DIV) ? (rem_reg[k-1] - DIV) : rem_reg[k-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else if (en)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
            end
        end
    end

    assign ctl_out = ctl_reg[QB];
    assign ax_out  = AXW'(rem_reg[QB]);

endmodule

[sv/sct_step.sv]
// One step of the series recurrence: multiply by |x| with rounding, then divide by n.
// Depends on sct_pkg; two register stages, and the running sum is updated on even steps.
module sct_step #(
    parameter int FRAC = 16,
    parameter int STEP = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  sct_pkg::ctl_t          ctl_in,
    input  logic [FRAC+7:0]        t_in,
    input  logic [FRAC+2:0]        ax_in,
    input  logic signed [FRAC+11:0] sum_in,
    output sct_pkg::ctl_t          ctl_out,
    output logic [FRAC+7:0]        t_out,
    output logic [FRAC+2:0]        ax_out,
    output logic signed [FRAC+11:0] sum_out
);
    import sct_pkg::*;

    localparam int TW  = FRAC + 8;
    localparam int AXW = FRAC + 3;
    localparam int SW  = FRAC + 12;
    localparam int PW  = TW + AXW;
    localparam int AW  = FRAC + 10;
    localparam int SH  = AW + 5;
    localparam int MW  = SH + 1;
    localparam int QW  = AW + MW;

    localparam int N_SIN = STEP + 2;
    localparam int N_COS = STEP + 1;
    localparam logic [MW-1:0] M_SIN = MW'(((64'd1 << SH) + N_SIN - 1) / N_SIN);
    localparam logic [MW-1:0] M_COS = MW'(((64'd1 << SH) + N_COS - 1) / N_COS);
    localparam logic [AW-1:0] H_SIN = AW'(N_SIN / 2);
    localparam logic [AW-1:0] H_COS = AW'(N_COS / 2);
    localparam logic [PW-1:0] RND   = PW'(1) << (FRAC - 1);
    localparam bit ACC = (STEP % 2) == 0;
    localparam bit SUB = ((STEP / 2) % 2) == 1;

    ctl_t                   ctl1_reg;
    ctl_t                   ctl2_reg;
    logic [PW-1:0]          prod_reg;
    logic [PW-1:0]          prod_next;
    logic [AXW-1:0]         ax1_reg;
    logic [AXW-1:0]         ax2_reg;
    logic signed [SW-1:0]   sum1_reg;
    logic signed [SW-1:0]   sum1_next;
    logic signed [SW-1:0]   sum2_reg;
    logic [QW-1:0]          quo_reg;
    logic [QW-1:0]          quo_next;
    logic [AW-1:0]          num;
    logic [MW-1:0]          recip;

    assign prod_next = PW'(t_in) * PW'(ax_in) + RND;

    always_comb
    begin
        sum1_next = sum_in;
        if (ACC)
        begin
            if (SUB)
            begin
                sum1_next = sum_in - $signed(SW'(t_in));
            end
            else
            begin
                sum1_next = sum_in + $signed(SW'(t_in));
            end
        end
    end

    // The reciprocal is exact for every numerator this stage can see.
    assign num      = AW'(prod_reg >> FRAC) + (ctl1_reg.cosine ? H_COS : H_SIN);
    assign recip    = ctl1_reg.cosine ? M_COS : M_SIN;
    assign quo_next = QW'(num) * QW'(recip);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            ax1_reg  <= ax_in;
            sum1_reg <= sum1_next;
            quo_reg  <= quo_next;
            ax2_reg  <= ax1_reg;
            sum2_reg <= sum1_reg;
        end
    end

    assign ctl_out = ctl2_reg;
    assign t_out   = TW'(quo_reg >> SH);
    assign ax_out  = ax2_reg;
    assign sum_out = sum2_reg;

endmodule

[sv/sct_output.sv]
// Back end of the series unit: adds the last term, applies the sine sign and saturates.
// Depends on sct_pkg; two register stages, the second being the output register.
module sct_output #(
    parameter int FRAC  = 16,
    parameter int TERMS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  sct_pkg::ctl_t                     ctl_in,
    input  logic [FRAC+7:0]                   t_in,
    input  logic signed [FRAC+11:0]           sum_in,
    output logic                              out_valid,
    output logic signed [sct_pkg::VALUE_W-1:0] value
);
    import sct_pkg::*;

    localparam int SW = FRAC + 12;
    localparam int XW = (SW > VALUE_W) ? SW : VALUE_W;
    localparam bit SUB = (TERMS % 2) == 1;
    localparam logic signed [XW-1:0] VMAX = XW'((64'd1 << (VALUE_W - 1)) - 1);
    localparam logic signed [XW-1:0] VMIN = -VMAX - XW'(1);

    ctl_t                      ctl_a_reg;
    logic signed [SW-1:0]      sum_a_reg;
    logic signed [SW-1:0]      sum_a_next;
    logic signed [SW-1:0]      signed_sum;
    logic signed [XW-1:0]      wide_sum;
    logic signed [VALUE_W-1:0] value_next;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      out_valid_reg;

    assign sum_a_next = SUB ? (sum_in - $signed(SW'(t_in))) : (sum_in + $signed(SW'(t_in)));

    // Sine is odd in the angle, cosine is even.
    assign signed_sum = (!ctl_a_reg.cosine && ctl_a_reg.neg) ? -sum_a_reg : sum_a_reg;
    assign wide_sum   = XW'(signed_sum);

    always_comb
    begin
        if (wide_sum > VMAX)
        begin
            value_next = VALUE_W'(VMAX);
        end
        else if (wide_sum < VMIN)
        begin
            value_next = VALUE_W'(VMIN);
        end
        else
        begin
            value_next = VALUE_W'(wide_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ctl_a_reg     <= ctl_in;
            out_valid_reg <= ctl_a_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_a_reg <= sum_a_next;
            value_reg <= value_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

endmodule
